@@ src/ecpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Excitation current PI regulator package
// Shared widths, register indexes, limits and the two breakpoint tables.
// ----------------------------------------------------------------------------
package ecpr_pkg;

   localparam int SPEED_W = 16;
   localparam int VOLT_W  = 12;
   localparam int CUR_W   = 12;
   localparam int GAIN_W  = 16;
   localparam int LEVEL_W = 5;
   localparam int DUTY_W  = 16;
   localparam int ERR_W   = 13;
   localparam int PROD_W  = GAIN_W + ERR_W;
   localparam int ACC_W   = 32;
   localparam int RATIO_W = 16;
   localparam int TGT_W   = 11;
   localparam int BP_IDX_W = 6;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_GAIN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVR_ENABLE = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVR_LEVEL  = 2'd3;

   localparam logic [VOLT_W-1:0] MIN_VOLTAGE = 12'd885;

   localparam int TABLE_ENTRIES = 20;
   localparam int SEARCH_LIMIT  = 14;

   // dividend is the speed magnitude followed by twelve zero bits
   localparam int DIV_SHIFT = 12;
   localparam int DIV_STEPS = RATIO_W + DIV_SHIFT;
   localparam int MUL_STEPS = GAIN_W;

   function automatic logic [RATIO_W-1:0] ratio_bp(input logic [BP_IDX_W-1:0] idx);
      logic [RATIO_W-1:0] val;
      unique case (idx)
         6'd0:    val = 16'd16087;
         6'd1:    val = 16'd8143;
         6'd2:    val = 16'd6784;
         6'd3:    val = 16'd5881;
         6'd4:    val = 16'd5099;
         6'd5:    val = 16'd4504;
         6'd6:    val = 16'd4033;
         6'd7:    val = 16'd3684;
         6'd8:    val = 16'd3407;
         6'd9:    val = 16'd3167;
         6'd10:   val = 16'd2957;
         6'd11:   val = 16'd2764;
         6'd12:   val = 16'd2670;
         6'd13:   val = 16'd2516;
         6'd14:   val = 16'd2438;
         6'd15:   val = 16'd2294;
         6'd16:   val = 16'd2104;
         6'd17:   val = 16'd2040;
         6'd18:   val = 16'd1966;
         6'd19:   val = 16'd1854;
         default: val = 16'd0;
      endcase
      return val;
   endfunction

   function automatic logic [TGT_W-1:0] cur_target(input logic [BP_IDX_W-1:0] idx);
      logic [TGT_W-1:0] val;
      unique case (idx)
         6'd0:    val = 11'd0;
         6'd1:    val = 11'd62;
         6'd2:    val = 11'd124;
         6'd3:    val = 11'd186;
         6'd4:    val = 11'd248;
         6'd5:    val = 11'd310;
         6'd6:    val = 11'd372;
         6'd7:    val = 11'd434;
         6'd8:    val = 11'd496;
         6'd9:    val = 11'd559;
         6'd10:   val = 11'd621;
         6'd11:   val = 11'd683;
         6'd12:   val = 11'd745;
         6'd13:   val = 11'd807;
         6'd14:   val = 11'd869;
         6'd15:   val = 11'd993;
         6'd16:   val = 11'd1117;
         6'd17:   val = 11'd1241;
         6'd18:   val = 11'd1489;
         6'd19:   val = 11'd1986;
         default: val = 11'd0;
      endcase
      return val;
   endfunction

endpackage

@@ src/excitation_current_pi_regulator.sv @@
// ----------------------------------------------------------------------------
// Excitation current PI regulator
// Picks a current level from the speed-per-volt ratio and runs a PI step
// on the excitation current error to produce the PWM duty word.
// ----------------------------------------------------------------------------
// Path: on the full path a word passes the serial divider, a breakpoint
//   search of up to 15 steps and the serial multiply before the result word;
//   when the level is 0 the multiply is skipped, and the divide is skipped by
//   override or low bus voltage.
// No new word is taken while one is in progress; the next word is taken once
//   the result is in the output register. Reset clears all control state, the
//   config registers and the integral term to zero.
// ----------------------------------------------------------------------------
module excitation_current_pi_regulator
   import ecpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // speed_raw[15:0], bus_voltage_raw[27:16], field_current_raw[39:28]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pwm_duty[15:0], level_index[20:16], zero fill
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIV  = 3'd1;
   localparam logic [2:0] S_SRCH = 3'd2;
   localparam logic [2:0] S_LVL  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_ACC  = 3'd5;
   localparam logic [2:0] S_DUTY = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0]               state_ff, state_in;
   logic [GAIN_W-1:0]        prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0]        integ_gain_ff, integ_gain_in;
   logic                     ovr_en_ff, ovr_en_in;
   logic [LEVEL_W-1:0]       ovr_level_ff, ovr_level_in;
   logic [CUR_W-1:0]         cur_ff, cur_in;
   logic [RATIO_W-1:0]       mag_ff, mag_in;
   logic [LEVEL_W-1:0]       idx_ff, idx_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic [DUTY_W-1:0]        p_lo_ff, p_lo_in;
   logic signed [PROD_W-1:0] ih_ff, ih_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]        rsp_duty_ff, rsp_duty_in;
   logic [LEVEL_W-1:0]       rsp_level_ff, rsp_level_in;

   logic                     req_accept;
   logic [SPEED_W-1:0]       spd;
   logic [VOLT_W-1:0]        volt;
   logic [RATIO_W-1:0]       spd_mag;
   logic                     low_volt;
   logic [LEVEL_W-1:0]       ovr_sat;
   logic                     slot_free;
   logic                     div_start, div_done;
   logic [RATIO_W-1:0]       div_quo;
   logic                     mul_start, mul_p_done, mul_i_done;
   logic signed [ERR_W-1:0]  err;
   logic signed [PROD_W-1:0] prod_p, prod_i;
   logic signed [PROD_W-1:0] prod_i_rnd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign spd        = req_tdata[15:0];
   assign volt       = req_tdata[27:16];
   assign spd_mag    = spd[SPEED_W-1] ? (~spd + 1'b1) : spd;
   assign low_volt   = (volt < MIN_VOLTAGE);
   assign ovr_sat    = (ovr_level_ff > LEVEL_W'(TABLE_ENTRIES - 1)) ?
                       LEVEL_W'(TABLE_ENTRIES - 1) : ovr_level_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign div_start  = req_accept && !ovr_en_ff && !low_volt;
   assign mul_start  = (state_ff == S_LVL) && (level_ff != '0);
   assign err        = $signed({2'b00, cur_target(BP_IDX_W'(level_ff))})
                       - $signed({1'b0, cur_ff});
   assign prod_i_rnd = prod_i + PROD_W'(prod_i[PROD_W-1]);

   ecpr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (spd_mag),
      .divisor  (volt),
      .done     (div_done),
      .quotient (div_quo)
   );

   ecpr_mul u_mul_p (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .gain    (prop_gain_ff),
      .err     (err),
      .done    (mul_p_done),
      .product (prod_p)
   );

   ecpr_mul u_mul_i (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .gain    (integ_gain_ff),
      .err     (err),
      .done    (mul_i_done),
      .product (prod_i)
   );

   always_comb begin
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      ovr_en_in     = ovr_en_ff;
      ovr_level_in  = ovr_level_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_in  = csr_wdata;
            CSR_INTEG_GAIN: integ_gain_in = csr_wdata;
            CSR_OVR_ENABLE: ovr_en_in     = csr_wdata[0];
            CSR_OVR_LEVEL:  ovr_level_in  = csr_wdata[LEVEL_W-1:0];
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      mag_in       = mag_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      p_lo_in      = p_lo_ff;
      ih_in        = ih_ff;
      acc_in       = acc_ff;
      duty_in      = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_level_in = rsp_level_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cur_in = req_tdata[39:28];
               if (ovr_en_ff) begin
                  level_in = ovr_sat;
                  state_in = S_LVL;
               end else if (low_volt) begin
                  level_in = '0;
                  state_in = S_LVL;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               mag_in   = div_quo;
               idx_in   = '0;
               state_in = S_SRCH;
            end
         end
         S_SRCH: begin
            priority if (idx_ff == LEVEL_W'(SEARCH_LIMIT)) begin
               level_in = LEVEL_W'(SEARCH_LIMIT);
               state_in = S_LVL;
            end else if (mag_ff > ratio_bp(BP_IDX_W'(idx_ff) + 1'b1)) begin
               level_in = idx_ff;
               state_in = S_LVL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_LVL: begin
            if (level_ff == '0) begin
               duty_in  = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_i_done && mul_p_done) begin
               p_lo_in  = prod_p[DUTY_W-1:0];
               ih_in    = prod_i_rnd >>> 1;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in   = acc_ff + ACC_W'(ih_ff);
            state_in = S_DUTY;
         end
         S_DUTY: begin
            duty_in  = p_lo_ff + acc_ff[DUTY_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_duty_in  = duty_ff;
               rsp_level_in = level_ff;
               state_in     = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         ovr_en_ff     <= 1'b0;
         ovr_level_ff  <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         ovr_en_ff     <= ovr_en_in;
         ovr_level_ff  <= ovr_level_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cur_ff       <= cur_in;
      mag_ff       <= mag_in;
      idx_ff       <= idx_in;
      level_ff     <= level_in;
      p_lo_ff      <= p_lo_in;
      ih_ff        <= ih_in;
      duty_ff      <= duty_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DUTY_W - LEVEL_W){1'b0}}, rsp_level_ff, rsp_duty_ff};

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result word raised outside the output step");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_level_ff <= LEVEL_W'(TABLE_ENTRIES - 1)))
      else $error("result level beyond the table");

   a_level_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_level_ff == '0)) |-> (rsp_duty_ff == '0))
      else $error("nonzero duty at level zero");

   a_acc_update: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(acc_ff)) |-> $past(state_ff == S_ACC))
      else $error("integral term changed outside the accumulate step");

   a_mul_pair: assert property (@(posedge clock) disable iff (reset)
      mul_p_done |-> mul_i_done)
      else $error("gain multipliers out of step");

endmodule

@@ src/ecpr_div.sv @@
// ----------------------------------------------------------------------------
// Bit-serial ratio divider
// Restoring divide of the speed magnitude times 4096 by the bus voltage,
// one quotient bit per cycle; keeps the low quotient bits only.
// ----------------------------------------------------------------------------
module ecpr_div
   import ecpr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RATIO_W-1:0] dividend,
   input  logic [VOLT_W-1:0]  divisor,
   output logic               done,
   output logic [RATIO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RATIO_W-1:0] dvd_ff, dvd_in;
   logic [VOLT_W-1:0]  dsr_ff, dsr_in;
   logic [VOLT_W-1:0]  rem_ff, rem_in;
   logic [RATIO_W-1:0] quo_ff, quo_in;

   logic              bit_in;
   logic [VOLT_W:0]   trial;
   logic [VOLT_W:0]   diff;
   logic              ge;

   always_comb begin
      bit_in = (cnt_ff < CNT_W'(RATIO_W)) ? dvd_ff[RATIO_W-1] : 1'b0;
      trial  = {rem_ff, bit_in};
      diff   = trial - {1'b0, dsr_ff};
      ge     = (trial >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RATIO_W-2:0], 1'b0};
         rem_in = ge ? diff[VOLT_W-1:0] : trial[VOLT_W-1:0];
         quo_in = {quo_ff[RATIO_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ src/ecpr_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial gain multiplier
// Shift-and-add product of an unsigned gain and a signed current error,
// one gain bit per cycle.
// ----------------------------------------------------------------------------
module ecpr_mul
   import ecpr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [GAIN_W-1:0]        gain,
   input  logic signed [ERR_W-1:0]  err,
   output logic                     done,
   output logic signed [PROD_W-1:0] product
);

   localparam int CNT_W = $clog2(MUL_STEPS);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic signed [PROD_W-1:0] mcand_ff, mcand_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      gain_in  = gain_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         gain_in  = gain;
         mcand_in = PROD_W'(err);
         acc_in   = '0;
      end else if (busy_ff) begin
         if (gain_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         gain_in  = gain_ff >> 1;
         mcand_in = mcand_ff <<< 1;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      gain_ff  <= gain_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
